@@ rtl/laplacian_sharpen_filter_assert.svh @@
// assertion macros for the laplacian sharpen filter
// no dependencies; included by the top level
`ifndef LAPLACIAN_SHARPEN_FILTER_ASSERT_SVH
`define LAPLACIAN_SHARPEN_FILTER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsf assertion failed");

// next-cycle implication
`define LSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsf assertion failed");

`endif

@@ rtl/lsf_pkg.sv @@
// shared types, constants and the sharpen arithmetic for the laplacian sharpen filter
// no dependencies
package lsf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int AMT_W      = 8;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [AMT_W-1:0]    AMT_RST    = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_SHARPEN_AMOUNT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_pos;

    // centre and the north, south, west and east neighbours of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] north;
        logic [PIX_W-1:0] south;
        logic [PIX_W-1:0] west;
        logic [PIX_W-1:0] east;
        logic [PIX_W-1:0] centre;
    } t_cross;

    // ((64 + amt) * c - 16 * ring) / 16, floored, clamped to 0..255
    function automatic logic [CH_W-1:0] sharpen_chan(
        input logic [CH_W-1:0]  c,
        input logic [CH_W-1:0]  n,
        input logic [CH_W-1:0]  s,
        input logic [CH_W-1:0]  w,
        input logic [CH_W-1:0]  e,
        input logic [AMT_W-1:0] amt
    );
        logic [16:0] prod;
        logic [16:0] ring16;
        logic [9:0]  ring;
        logic [16:0] diff;
        logic [12:0] q;
        logic [CH_W-1:0] res;
        ring   = 10'(n) + 10'(s) + 10'(w) + 10'(e);
        ring16 = {3'b000, ring, 4'b0000};
        prod   = 17'({1'b0, amt} + 9'd64) * 17'(c);
        diff   = prod - ring16;
        q      = diff[16:4];
        if (prod < ring16) begin
            res = '0;
        end else if (q > 13'd255) begin
            res = 8'd255;
        end else begin
            res = q[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] chan_of(input logic [PIX_W-1:0] px, input int unsigned k);
        return px[k*CH_W +: CH_W];
    endfunction

endpackage

@@ rtl/laplacian_sharpen_filter.sv @@
// Laplacian sharpen filter: RGB pixels in raster order in, sharpened interior pixels out.
// Takes one pixel per clock whenever the output side keeps up. Two line buffers in one
// dual-port ram (read at accept, written back from the stage-1 registers) feed a 3x3 window;
// the cross sum, one 9x8 multiply per channel and the clamp sit between the window and the
// result register. The accepted pixel completing the window, one column right of and one row
// below the result, passes the window/stage-2 and result registers. Border pixels give no
// result. The line buffers need no clearing after reset. The user writes sizes and sharpen
// amount via the register port only while the stream is idle; the block does not enforce it.
// depends on lsf_pkg, lsf_line_ram, lsf_pos_ctr, lsf_window and the assertion header
module laplacian_sharpen_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_frame_start,
    input  logic [lsf_pkg::CH_W-1:0]       i_red_in,
    input  logic [lsf_pkg::CH_W-1:0]       i_green_in,
    input  logic [lsf_pkg::CH_W-1:0]       i_blue_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lsf_pkg::COL_W-1:0]      o_out_column,
    output logic [lsf_pkg::ROW_W-1:0]      o_out_row,
    output logic [lsf_pkg::CH_W-1:0]       o_red_out,
    output logic [lsf_pkg::CH_W-1:0]       o_green_out,
    output logic [lsf_pkg::CH_W-1:0]       o_blue_out
);
    import lsf_pkg::*;
    `include "laplacian_sharpen_filter_assert.svh"

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [AMT_W-1:0]    r_sharpen_amount;

    logic               en;
    logic               acc;
    t_pos               pos;

    logic               r_s1_valid;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    logic [PIX_W-1:0]   r_s1_cur;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] s1_lines;
    logic [2*PIX_W-1:0] n_lines;
    logic               s1_interior;

    logic               r_s2_valid;
    logic [COL_W-1:0]   r_s2_col;
    logic [ROW_W-1:0]   r_s2_row;
    t_cross             win_cross;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [PIX_W-1:0]   r_out_pix;
    logic [PIX_W-1:0]   n_out_pix;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= WIDTH_RST;
            r_image_height   <= HEIGHT_RST;
            r_sharpen_amount <= AMT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data[HEIGHT_W-1:0];
                REG_SHARPEN_AMOUNT: r_sharpen_amount <= i_cfg_data[AMT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when the result register is free or being drained
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    lsf_pos_ctr u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (acc),
        .i_frame_start  (i_frame_start),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_pos          (pos)
    );

    // upper half older line, lower half newer line
    assign s1_lines = r_fwd ? r_fwd_data : ram_q;
    assign n_lines  = {s1_lines[PIX_W-1:0], r_s1_cur};

    lsf_line_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (en && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (n_lines),
        .i_re    (acc),
        .i_raddr (pos.col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
            // same column written this beat: the ram read misses it
            r_fwd      <= acc && r_s1_valid && (r_s1_col == pos.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col   <= pos.col;
            r_s1_row   <= pos.row;
            r_s1_cur   <= {i_blue_in, i_green_in, i_red_in};
            r_fwd_data <= n_lines;
        end
    end

    lsf_window u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (en && r_s1_valid),
        .i_top   (s1_lines[2*PIX_W-1:PIX_W]),
        .i_mid   (s1_lines[PIX_W-1:0]),
        .i_cur   (r_s1_cur),
        .o_cross (win_cross)
    );

    assign s1_interior = (r_s1_col >= COL_W'(2)) && (r_s1_row >= ROW_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && s1_interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_col <= r_s1_col - COL_W'(1);
            r_s2_row <= r_s1_row - ROW_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out_pix[k*CH_W +: CH_W] = sharpen_chan(
                chan_of(win_cross.centre, k), chan_of(win_cross.north, k),
                chan_of(win_cross.south, k), chan_of(win_cross.west, k),
                chan_of(win_cross.east, k), r_sharpen_amount);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid) begin
            r_out_col <= r_s2_col;
            r_out_row <= r_s2_row;
            r_out_pix <= n_out_pix;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_red_out    = r_out_pix[CH_W-1:0];
    assign o_green_out  = r_out_pix[2*CH_W-1:CH_W];
    assign o_blue_out   = r_out_pix[3*CH_W-1:2*CH_W];

    `LSF_ASSERT_NXT(a_s2_held, i_clk, i_rst_n, r_s2_valid && !en, r_s2_valid)
    `LSF_ASSERT_IMP(a_out_interior, i_clk, i_rst_n, o_valid, (o_out_column != '0) && (o_out_row != '0))
    `LSF_ASSERT_IMP(a_fwd_has_item, i_clk, i_rst_n, r_fwd, r_s1_valid)

endmodule

@@ rtl/lsf_line_ram.sv @@
// simple dual port ram, one write and one registered read port
// no dependencies
module lsf_line_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on an address clash
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lsf_pos_ctr.sv @@
// column and row position of the incoming pixel within its frame
// depends on lsf_pkg
module lsf_pos_ctr (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_frame_start,
    input  logic [lsf_pkg::WIDTH_W-1:0]  i_image_width,
    input  logic [lsf_pkg::HEIGHT_W-1:0] i_image_height,
    output lsf_pkg::t_pos                o_pos
);
    import lsf_pkg::*;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    x;
    logic [ROW_W-1:0]    y;
    logic                col_last;
    logic                row_last;

    // zero reads as one, oversize saturates
    always_comb begin
        if (i_image_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (i_image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = i_image_width;
        end
        if (i_image_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (i_image_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_image_height;
        end
    end

    assign x        = i_frame_start ? '0 : r_col;
    assign y        = i_frame_start ? '0 : r_row;
    assign col_last = ({1'b0, x} + WIDTH_W'(1)) >= w_eff;
    assign row_last = ({1'b0, y} + HEIGHT_W'(1)) >= h_eff;

    always_comb begin
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : y + ROW_W'(1);
        end else begin
            n_col = x + COL_W'(1);
            n_row = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col = x;
    assign o_pos.row = y;

endmodule

@@ rtl/lsf_window.sv @@
// 3x3 sliding pixel window, shifted one column per pixel
// depends on lsf_pkg
module lsf_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [lsf_pkg::PIX_W-1:0] i_top,
    input  logic [lsf_pkg::PIX_W-1:0] i_mid,
    input  logic [lsf_pkg::PIX_W-1:0] i_cur,
    output lsf_pkg::t_cross           o_cross
);
    import lsf_pkg::*;

    logic [PIX_W-1:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_cur;
        end
    end

    assign o_cross.north  = r_win[0][1];
    assign o_cross.south  = r_win[2][1];
    assign o_cross.west   = r_win[1][0];
    assign o_cross.east   = r_win[1][2];
    assign o_cross.centre = r_win[1][1];

endmodule
